// File: design/cgs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and color functions for the CGA graphics scan-out.
// No dependencies; every other file in design/ except cgs_ram imports this package.
package cgs_pkg;

  // Video memory geometry
  localparam int MEM_BYTES  = 16384;
  localparam int MEM_AW     = $clog2(MEM_BYTES);
  localparam int BANK_BYTES = 8192;                 // power of two, 4096..32768
  localparam int OFS_W      = $clog2(BANK_BYTES);   // line base / offset width

  // Scan position widths
  localparam int COL_W  = 9;
  localparam int LINE_W = 9;

  // Decoupling queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Command codes
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RENDER  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 14;
  localparam logic [CFG_IW-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COLSEL = 3'd1;
  localparam logic [CFG_IW-1:0] REG_START  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 3'd4;

  // Register bit positions
  localparam int MODE_BURST_BIT = 2;
  localparam int MODE_HIRES_BIT = 4;
  localparam int CS_INTENS_BIT  = 4;
  localparam int CS_PAL_BIT     = 5;

  typedef struct packed {
    logic [5:0]        mode_bits;
    logic [5:0]        color_select;
    logic [MEM_AW-1:0] start_address;
    logic [7:0]        row_width;
    logic [7:0]        row_count;
  } cfg_t;

  // One fetched byte with its scan flags
  typedef struct packed {
    logic [7:0] data;
    logic       line_end;
    logic       frame_end;
  } entry_t;

  // Front status seen by the top level
  typedef struct packed {
    logic clearing;
    logic pending;
  } front_stat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Four-color palette for two-bit pixels
  function automatic logic [3:0] pal_lookup(input logic [5:0] mode_bits,
                                            input logic [5:0] color_select,
                                            input logic [1:0] code);
    logic [2:0] base;
    logic [3:0] idx;
    base = 3'd0;
    if (mode_bits[MODE_BURST_BIT]) begin
      case (code)
        2'd1:    base = 3'd3;
        2'd2:    base = 3'd4;
        default: base = 3'd7;
      endcase
    end else if (color_select[CS_PAL_BIT]) begin
      case (code)
        2'd1:    base = 3'd3;
        2'd2:    base = 3'd5;
        default: base = 3'd7;
      endcase
    end else begin
      case (code)
        2'd1:    base = 3'd2;
        2'd2:    base = 3'd4;
        default: base = 3'd6;
      endcase
    end
    if (code == 2'd0) begin
      idx = color_select[3:0];
    end else begin
      idx = {color_select[CS_INTENS_BIT], base};
    end
    return idx;
  endfunction

  // Fixed sixteen-color table
  function automatic rgb_t rgb_lookup(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{8'h00, 8'h00, 8'h00};
      4'd1:    c = '{8'h00, 8'h00, 8'haa};
      4'd2:    c = '{8'h00, 8'haa, 8'h00};
      4'd3:    c = '{8'h00, 8'haa, 8'haa};
      4'd4:    c = '{8'haa, 8'h00, 8'h00};
      4'd5:    c = '{8'haa, 8'h00, 8'haa};
      4'd6:    c = '{8'haa, 8'h55, 8'h00};
      4'd7:    c = '{8'haa, 8'haa, 8'haa};
      4'd8:    c = '{8'h55, 8'h55, 8'h55};
      4'd9:    c = '{8'h55, 8'h55, 8'hff};
      4'd10:   c = '{8'h55, 8'hff, 8'h55};
      4'd11:   c = '{8'h55, 8'hff, 8'hff};
      4'd12:   c = '{8'hff, 8'h55, 8'h55};
      4'd13:   c = '{8'hff, 8'h55, 8'hff};
      4'd14:   c = '{8'hff, 8'hff, 8'h55};
      default: c = '{8'hff, 8'hff, 8'hff};
    endcase
    return c;
  endfunction

endpackage

// File: design/cgs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands in and pixels out.
// Depends on cgs_pkg for field widths.
interface cgs_in_if;
  import cgs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [MEM_AW-1:0] mem_address;
  logic [7:0]       write_data;

  modport source (output valid, command, mem_address, write_data, input ready);
  modport sink   (input valid, command, mem_address, write_data, output ready);
endinterface

interface cgs_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] color_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_of_byte;
  logic       line_end;
  logic       frame_end;

  modport source (output valid, color_index, red, green, blue, last_of_byte,
                  line_end, frame_end, input ready);
  modport sink   (input valid, color_index, red, green, blue, last_of_byte,
                  line_end, frame_end, output ready);
endinterface

// File: design/cgs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/cgs_queue.sv
`timescale 1ns / 1ps
// Short FIFO of fetched bytes between the front and the back.
// Depends on cgs_pkg (entry_t, QDEPTH).
module cgs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cgs_pkg::entry_t     push_data,
  input  logic                pop,
  output cgs_pkg::entry_t     head,
  output logic                head_valid,
  output logic [cgs_pkg::QCW-1:0] count
);
  import cgs_pkg::*;

  entry_t            slot_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    count_r, count_nxt;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

endmodule

// File: design/cgs_front.sv
`timescale 1ns / 1ps
// Command front end: clears and writes video memory, walks the scan
// position and fetches render bytes into the queue. Depends on cgs_pkg,
// cgs_if and cgs_ram.
module cgs_front (
  input  logic                    clk,
  input  logic                    rst_n,
  cgs_in_if.sink                  in_ch,
  input  cgs_pkg::cfg_t           cfg,
  input  logic [cgs_pkg::QCW-1:0] q_count,
  output logic                    q_push,
  output cgs_pkg::entry_t         q_data,
  output cgs_pkg::front_stat_t    stat
);
  import cgs_pkg::*;

  logic              clr_r, clr_nxt;
  logic [MEM_AW-1:0] clr_addr_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [OFS_W-1:0]  base_r, base_nxt;
  logic              pend_r;
  logic              pend_le_r, pend_fe_r;

  logic              accept;
  logic              is_write, is_restart, is_render;
  logic [COL_W-1:0]  line_bytes;
  logic [LINE_W-1:0] frame_lines;
  logic              le, fe;
  logic [OFS_W-1:0]  ofs;
  logic [OFS_W:0]    bank_addr;
  logic [OFS_W-1:0]  restart_base;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [MEM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Room is counted with the fetch still in flight.
  assign in_ch.ready = !clr_r &&
      (({1'b0, q_count} + (QCW + 1)'(pend_r)) < (QCW + 1)'(QDEPTH));

  assign accept     = in_ch.valid && in_ch.ready;
  assign is_write   = accept && (in_ch.command == CMD_WRITE);
  assign is_restart = accept && (in_ch.command == CMD_RESTART);
  assign is_render  = accept && (in_ch.command == CMD_RENDER);

  assign line_bytes  = {cfg.row_width, 1'b0};
  assign frame_lines = {cfg.row_count, 1'b0};
  assign le = ({1'b0, col_r} + 1'b1) >= {1'b0, line_bytes};
  assign fe = le && (({1'b0, line_r} + 1'b1) >= {1'b0, frame_lines});

  assign ofs          = base_r + OFS_W'(col_r);
  assign bank_addr    = {line_r[0], ofs};
  assign ram_raddr    = MEM_AW'(bank_addr);
  assign restart_base = OFS_W'({cfg.start_address, 1'b0});

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    base_nxt = base_r;
    if (is_restart || (is_render && fe)) begin
      col_nxt  = '0;
      line_nxt = '0;
      base_nxt = restart_base;
    end else if (is_render && le) begin
      if (line_r[0]) begin
        base_nxt = base_r + OFS_W'(line_bytes);
      end
      col_nxt  = '0;
      line_nxt = line_r + 1'b1;
    end else if (is_render) begin
      col_nxt = col_r + 1'b1;
    end
  end

  assign clr_nxt = clr_r && (clr_addr_r != '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      col_r      <= '0;
      line_r     <= '0;
      base_r     <= '0;
      pend_r     <= 1'b0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_r ? clr_addr_r + 1'b1 : clr_addr_r;
      col_r      <= col_nxt;
      line_r     <= line_nxt;
      base_r     <= base_nxt;
      pend_r     <= is_render;
    end
  end

  always_ff @(posedge clk) begin
    if (is_render) begin
      pend_le_r <= le;
      pend_fe_r <= fe;
    end
  end

  // Clear sweep owns the write port until it finishes.
  assign ram_we    = clr_r || is_write;
  assign ram_waddr = clr_r ? clr_addr_r : in_ch.mem_address;
  assign ram_wdata = clr_r ? 8'h00 : in_ch.write_data;

  cgs_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (is_render),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_push         = pend_r;
  assign q_data.data    = ram_rdata;
  assign q_data.line_end  = pend_le_r;
  assign q_data.frame_end = pend_fe_r;

  assign stat.clearing = clr_r;
  assign stat.pending  = pend_r;

endmodule

// File: design/cgs_back.sv
`timescale 1ns / 1ps
// Pixel back end: takes fetched bytes from the queue and shifts them out one
// pixel per clock, while bytes are queued and out_ch is not stalled, through the
// palette (two-bit mode) and color table. Depends on cgs_pkg and cgs_if.
module cgs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  cgs_pkg::cfg_t   cfg,
  input  cgs_pkg::entry_t q_head,
  input  logic            q_valid,
  output logic            q_pop,
  cgs_out_if.source       out_ch
);
  import cgs_pkg::*;

  logic       busy_r, busy_nxt;
  logic [7:0] sh_r;
  logic [2:0] cnt_r;
  logic       le_r, fe_r;

  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_idx_r;
  rgb_t       out_rgb_r;
  logic       out_last_r, out_le_r, out_fe_r;

  logic       one_bit;
  logic [3:0] pix_idx;
  logic       last_pix;
  logic       emit;

  assign one_bit = cfg.mode_bits[MODE_HIRES_BIT];

  always_comb begin
    if (one_bit) begin
      pix_idx  = sh_r[7] ? cfg.color_select[3:0] : 4'd0;
      last_pix = (cnt_r == 3'd7);
    end else begin
      pix_idx  = pal_lookup(cfg.mode_bits, cfg.color_select, sh_r[7:6]);
      last_pix = (cnt_r == 3'd3);
    end
  end

  assign emit  = busy_r && (!out_valid_r || out_ch.ready);
  assign q_pop = q_valid && (!busy_r || (emit && last_pix));

  always_comb begin
    busy_nxt = busy_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
    end else if (emit && last_pix) begin
      busy_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sh_r  <= q_head.data;
      cnt_r <= '0;
      le_r  <= q_head.line_end;
      fe_r  <= q_head.frame_end;
    end else if (emit) begin
      sh_r  <= one_bit ? {sh_r[6:0], 1'b0} : {sh_r[5:0], 2'b00};
      cnt_r <= cnt_r + 1'b1;
    end
    if (emit) begin
      out_idx_r  <= pix_idx;
      out_rgb_r  <= rgb_lookup(pix_idx);
      out_last_r <= last_pix;
      out_le_r   <= le_r;
      out_fe_r   <= fe_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.color_index  = out_idx_r;
  assign out_ch.red          = out_rgb_r.red;
  assign out_ch.green        = out_rgb_r.green;
  assign out_ch.blue         = out_rgb_r.blue;
  assign out_ch.last_of_byte = out_last_r;
  assign out_ch.line_end     = out_le_r;
  assign out_ch.frame_end    = out_fe_r;

endmodule

// File: design/cga_graphics_scanout.sv
`timescale 1ns / 1ps
// Top level of the CGA graphics-mode scan-out: configuration registers, the
// command front end, the byte queue and the pixel back end. Depends on
// cgs_pkg, cgs_if, cgs_ram, cgs_queue, cgs_front and cgs_back.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  in_ch    | in  | valid/ready        | command, mem_address, write_data
//  out_ch   | out | valid/ready        | color_index, red, green, blue,
//           |     |                    | last_of_byte, line_end, frame_end
//  cfg_*    | in  | cfg_we, no stall   | cfg_index, cfg_wdata (14 bits)
//
// Write and restart transactions emit no pixels; a render emits 4 pixels (two-bit
// mode) or 8 (one-bit mode) at one per clock while out_ch is not stalled.
// After reset the front clears the 16384-byte video memory one byte per cycle,
// and in_ch.ready stays low until the clear ends; config writes are still taken.
// in_ch.ready also drops while the two-entry queue plus the fetch in flight is
// full; the queue lets the front run ahead while the back shifts or stalls.
module cga_graphics_scanout (
  input  logic                       clk,
  input  logic                       rst_n,
  cgs_in_if.sink                     in_ch,
  cgs_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [cgs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [cgs_pkg::CFG_DW-1:0] cfg_wdata
);
  import cgs_pkg::*;

  // Configuration registers
  cfg_t        cfg_r, cfg_nxt;

  // Front/back plumbing
  logic        q_push;
  entry_t      q_in;
  logic        q_pop;
  entry_t      q_head;
  logic        q_valid;
  logic [QCW-1:0] q_count;
  front_stat_t front_stat;

  // Register writes: unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   cfg_nxt.mode_bits     = cfg_wdata[5:0];
        REG_COLSEL: cfg_nxt.color_select  = cfg_wdata[5:0];
        REG_START:  cfg_nxt.start_address = cfg_wdata[MEM_AW-1:0];
        REG_WIDTH:  cfg_nxt.row_width     = cfg_wdata[7:0];
        REG_HEIGHT: cfg_nxt.row_count     = cfg_wdata[7:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: memory clear, writes, scan walk, byte fetch
  cgs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_count (q_count),
    .q_push  (q_push),
    .q_data  (q_in),
    .stat    (front_stat)
  );

  // Fetched bytes waiting for the shifter
  cgs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid),
    .count      (q_count)
  );

  // Back: pixel shifter and output register
  cgs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  // No command is taken while the memory clear is running.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
      front_stat.clearing |-> !in_ch.ready)
    else $error("command accepted during memory clear");

  // An accepted render is pushed into the queue in the next cycle.
  a_render_pushes: assert property (@(posedge clk) disable iff (!rst_n)
      (in_ch.valid && in_ch.ready && (in_ch.command == CMD_RENDER)) |=> q_push)
    else $error("render fetch did not reach the queue");

  // Queue never overfills, counting the fetch in flight.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
      ({1'b0, q_count} + (QCW + 1)'(front_stat.pending)) <= (QCW + 1)'(QDEPTH))
    else $error("byte queue overflow");

  // Queue is only popped when it holds a byte.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
      q_pop |-> (q_count != '0))
    else $error("pop from empty byte queue");
`endif

endmodule
